// File: sv/tmbd_pkg.sv
// Shared types and constants for the tagged matrix block deframer.
// No dependencies; the front, queue, back and top-level files import this package.
package tmbd_pkg;

	localparam int NUMBER_BYTES = 8;
	localparam int TYPE_BYTES = 4;
	localparam int STRING_LIMIT = 1024;

	localparam logic [31:0] START_MARK = 32'h4b636c42;
	localparam logic [31:0] END_MARK = 32'h426c634b;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_BLKLEN,
		PH_NAMELEN,
		PH_NAME,
		PH_COLCOUNT,
		PH_CNAMELEN,
		PH_CNAME,
		PH_CTYPE,
		PH_ROWS,
		PH_COLS,
		PH_DATA,
		PH_END
	} phase_t;

	localparam logic [2:0] RK_NAME = 3'd0;
	localparam logic [2:0] RK_CNAME = 3'd1;
	localparam logic [2:0] RK_CTYPE = 3'd2;
	localparam logic [2:0] RK_DIMS = 3'd3;
	localparam logic [2:0] RK_DATA = 3'd4;
	localparam logic [2:0] RK_ACCEPT = 3'd5;
	localparam logic [2:0] RK_REJECT = 3'd6;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_EOS = 2'd2;
	localparam logic [1:0] ERR_END_MARK = 2'd3;

	// One decoded result on its way from the front to the back.
	// word_a: column index for column results, row count for dimensions.
	// word_b: column count for dimensions.
	typedef struct packed {
		logic [2:0] rkind;
		logic [7:0] data;
		logic last;
		logic [1:0] err;
		logic [31:0] word_a;
		logic [31:0] word_b;
	} cmd_t;

endpackage

// File: sv/tmbd_if.sv
// Handshake channels of the deframer: byte stream in, result items out.
// No dependencies.
interface tmbd_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface tmbd_out_if;
	logic valid;
	logic ready;
	logic [2:0] result_kind;
	logic [7:0] out_byte;
	logic last_of_field;
	logic [31:0] column_number;
	logic [31:0] row_count;
	logic [31:0] column_count;
	logic [1:0] error_code;

	modport source (output valid, output result_kind, output out_byte, output last_of_field,
		output column_number, output row_count, output column_count, output error_code,
		input ready);
	modport sink (input valid, input result_kind, input out_byte, input last_of_field,
		input column_number, input row_count, input column_count, input error_code,
		output ready);
endinterface

// File: sv/tmbd_front.sv
// Front of the deframer: accepts stream items, tracks the block phase and
// pushes decoded results into the queue. Depends on tmbd_pkg and tmbd_if.
module tmbd_front (
	input logic clk,
	input logic arst_n,
	tmbd_in_if.sink stream,
	input logic q_full,
	output logic q_push,
	output tmbd_pkg::cmd_t q_cmd
);
	import tmbd_pkg::*;

	phase_t phase_q, phase_d;
	logic [31:0] window_q, window_d;
	logic [31:0] fcnt_q, fcnt_d;
	logic [23:0] acc_q, acc_d;
	logic [31:0] ctot_q, ctot_d;
	logic [31:0] cpos_q, cpos_d;
	logic [31:0] rows_q, rows_d;
	logic [31:0] rnb_q, rnb_d;
	logic halted_q, halted_d;

	logic accept;
	logic emit;
	logic rej;
	logic [1:0] rej_code;
	logic [31:0] word;
	logic word_done;
	logic cnt_last;
	logic [31:0] cnt_dec;
	logic [31:0] cpos_inc;
	logic [31:0] dsize;

	assign stream.ready = !q_full;
	assign accept = stream.valid && stream.ready;
	assign q_push = accept && emit;

	// little-endian word: three bytes already held plus the current one
	assign word = {stream.in_byte, acc_q};
	assign word_done = (fcnt_q[1:0] == 2'd3);
	assign cnt_last = (fcnt_q == 32'd1);
	assign cnt_dec = fcnt_q - 32'd1;
	assign cpos_inc = cpos_q + 32'd1;
	// rnb_q already holds rows*NUMBER_BYTES, so one multiply gives the data size
	assign dsize = rnb_q * word;

	always_comb begin
		phase_d = phase_q;
		window_d = window_q;
		fcnt_d = fcnt_q;
		acc_d = acc_q;
		ctot_d = ctot_q;
		cpos_d = cpos_q;
		rows_d = rows_q;
		rnb_d = rnb_q;
		halted_d = halted_q;
		emit = 1'b0;
		rej = 1'b0;
		rej_code = ERR_NONE;
		q_cmd = '0;

		if (accept && !halted_q) begin
			if (stream.kind) begin
				if (phase_q == PH_HUNT) begin
					halted_d = 1'b1;
				end else begin
					rej = 1'b1;
					rej_code = ERR_EOS;
				end
			end else begin
				// word collection for the length and marker phases
				if (phase_q == PH_BLKLEN || phase_q == PH_NAMELEN || phase_q == PH_COLCOUNT ||
					phase_q == PH_CNAMELEN || phase_q == PH_ROWS || phase_q == PH_COLS ||
					phase_q == PH_END) begin
					fcnt_d = word_done ? 32'd0 : fcnt_q + 32'd1;
					case (fcnt_q[1:0])
						2'd0: acc_d[7:0] = stream.in_byte;
						2'd1: acc_d[15:8] = stream.in_byte;
						2'd2: acc_d[23:16] = stream.in_byte;
						default: acc_d = acc_q;
					endcase
				end

				case (phase_q)
					PH_HUNT: begin
						window_d = {stream.in_byte, window_q[31:8]};
						if (window_d == START_MARK) begin
							fcnt_d = 32'd0;
							phase_d = PH_BLKLEN;
						end
					end
					PH_BLKLEN: begin
						if (word_done) begin
							phase_d = PH_NAMELEN;
						end
					end
					PH_NAMELEN: begin
						if (word_done) begin
							if (word > 32'(STRING_LIMIT)) begin
								rej = 1'b1;
								rej_code = ERR_TOO_LONG;
							end else if (word == 32'd0) begin
								phase_d = PH_COLCOUNT;
							end else begin
								fcnt_d = word;
								phase_d = PH_NAME;
							end
						end
					end
					PH_NAME: begin
						fcnt_d = cnt_dec;
						if (cnt_last) begin
							phase_d = PH_COLCOUNT;
						end
						emit = 1'b1;
						q_cmd.rkind = RK_NAME;
						q_cmd.data = stream.in_byte;
						q_cmd.last = cnt_last;
					end
					PH_COLCOUNT: begin
						if (word_done) begin
							ctot_d = word;
							cpos_d = 32'd0;
							phase_d = (word == 32'd0) ? PH_ROWS : PH_CNAMELEN;
						end
					end
					PH_CNAMELEN: begin
						if (word_done) begin
							if (word > 32'(STRING_LIMIT)) begin
								rej = 1'b1;
								rej_code = ERR_TOO_LONG;
							end else if (word == 32'd0) begin
								fcnt_d = 32'(TYPE_BYTES);
								phase_d = PH_CTYPE;
							end else begin
								fcnt_d = word;
								phase_d = PH_CNAME;
							end
						end
					end
					PH_CNAME: begin
						fcnt_d = cnt_dec;
						if (cnt_last) begin
							fcnt_d = 32'(TYPE_BYTES);
							phase_d = PH_CTYPE;
						end
						emit = 1'b1;
						q_cmd.rkind = RK_CNAME;
						q_cmd.data = stream.in_byte;
						q_cmd.last = cnt_last;
						q_cmd.word_a = cpos_q;
					end
					PH_CTYPE: begin
						fcnt_d = cnt_dec;
						if (cnt_last) begin
							cpos_d = cpos_inc;
							phase_d = (cpos_inc >= ctot_q) ? PH_ROWS : PH_CNAMELEN;
						end
						emit = 1'b1;
						q_cmd.rkind = RK_CTYPE;
						q_cmd.data = stream.in_byte;
						q_cmd.last = cnt_last;
						q_cmd.word_a = cpos_q;
					end
					PH_ROWS: begin
						if (word_done) begin
							rows_d = word;
							rnb_d = word * 32'(NUMBER_BYTES);
							phase_d = PH_COLS;
						end
					end
					PH_COLS: begin
						if (word_done) begin
							fcnt_d = dsize;
							phase_d = (dsize == 32'd0) ? PH_END : PH_DATA;
							emit = 1'b1;
							q_cmd.rkind = RK_DIMS;
							q_cmd.word_a = rows_q;
							q_cmd.word_b = word;
						end
					end
					PH_DATA: begin
						fcnt_d = cnt_dec;
						if (cnt_last) begin
							phase_d = PH_END;
						end
						emit = 1'b1;
						q_cmd.rkind = RK_DATA;
						q_cmd.data = stream.in_byte;
						q_cmd.last = cnt_last;
					end
					PH_END: begin
						if (word_done) begin
							if (word != END_MARK) begin
								rej = 1'b1;
								rej_code = ERR_END_MARK;
							end else begin
								phase_d = PH_HUNT;
								window_d = 32'd0;
								emit = 1'b1;
								q_cmd = '0;
								q_cmd.rkind = RK_ACCEPT;
							end
						end
					end
					default: begin
						phase_d = PH_HUNT;
						window_d = 32'd0;
					end
				endcase
			end

			if (rej) begin
				halted_d = 1'b1;
				phase_d = PH_HUNT;
				emit = 1'b1;
				q_cmd = '0;
				q_cmd.rkind = RK_REJECT;
				q_cmd.err = rej_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			window_q <= '0;
			fcnt_q <= '0;
			acc_q <= '0;
			ctot_q <= '0;
			cpos_q <= '0;
			rows_q <= '0;
			rnb_q <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			window_q <= window_d;
			fcnt_q <= fcnt_d;
			acc_q <= acc_d;
			ctot_q <= ctot_d;
			cpos_q <= cpos_d;
			rows_q <= rows_d;
			rnb_q <= rnb_d;
			halted_q <= halted_d;
		end
	end

endmodule

// File: sv/tmbd_queue.sv
// Two-entry queue of decoded results between front and back.
// Depends on tmbd_pkg.
module tmbd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tmbd_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic valid,
	output tmbd_pkg::cmd_t head
);
	import tmbd_pkg::*;

	cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/tmbd_back.sv
// Back of the deframer: takes decoded results from the queue, expands them
// into the result fields and holds them in the output register.
// Depends on tmbd_pkg and tmbd_if.
module tmbd_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input tmbd_pkg::cmd_t q_head,
	output logic q_pop,
	tmbd_out_if.source result
);
	import tmbd_pkg::*;

	logic valid_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic last_q;
	logic [31:0] colnum_q;
	logic [31:0] rows_q;
	logic [31:0] cols_q;
	logic [1:0] err_q;
	logic is_col;
	logic is_dims;

	assign q_pop = q_valid && (!valid_q || result.ready);
	assign is_col = (q_head.rkind == RK_CNAME) || (q_head.rkind == RK_CTYPE);
	assign is_dims = (q_head.rkind == RK_DIMS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_head.rkind;
			byte_q <= q_head.data;
			last_q <= q_head.last;
			colnum_q <= is_col ? q_head.word_a : 32'd0;
			rows_q <= is_dims ? q_head.word_a : 32'd0;
			cols_q <= is_dims ? q_head.word_b : 32'd0;
			err_q <= q_head.err;
		end
	end

	assign result.valid = valid_q;
	assign result.result_kind = kind_q;
	assign result.out_byte = byte_q;
	assign result.last_of_field = last_q;
	assign result.column_number = colnum_q;
	assign result.row_count = rows_q;
	assign result.column_count = cols_q;
	assign result.error_code = err_q;

endmodule

// File: sv/tagged_matrix_block_deframer_core.sv
// Top level of the tagged matrix block deframer: front, queue and back.
// Depends on tmbd_pkg, tmbd_if, tmbd_front, tmbd_queue and tmbd_back.

// The deframer takes one stream byte (or an end-of-stream mark) per cycle
// while its queue is not full and gives at most one result item per byte;
// with the output side ready it sustains one item per clock. The front
// decodes each byte in the cycle it is accepted, and the data size
// (rows*cols*bytes per number) comes from one 32x32 multiply done as the last
// column-count byte arrives. Results then pass a two-entry queue and an output
// register, and input keeps flowing while a result waits, until the queue is
// full. A block that is rejected, or the stream ending, halts the deframer
// until reset; the input is still taken but produces nothing.
module tagged_matrix_block_deframer_core (
	input logic clk,
	input logic arst_n,
	tmbd_in_if.sink stream,
	tmbd_out_if.source result
);
	import tmbd_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;
	cmd_t q_head;

	tmbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	tmbd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	tmbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.result(result)
	);

	// a queued result always reaches an empty output register next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !result.valid |=> result.valid)
		else $error("queued item not moved to output register");

	// error code set exactly on rejections
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.result_kind == RK_REJECT) == (result.error_code != ERR_NONE)))
		else $error("error code does not match result kind");

	// end-of-field flag only on byte-carrying items
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last_of_field |->
			(result.result_kind == RK_NAME || result.result_kind == RK_CNAME ||
			result.result_kind == RK_CTYPE || result.result_kind == RK_DATA))
		else $error("last flag on an item without bytes");

endmodule
